@@ rtl/sfqd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfqd_pkg: shared types and constants of the fair queueing scheduler
// Holds the entry layout, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package sfqd_pkg;

    localparam int QUEUE_ENTRIES_DEF = 64;
    localparam int NUM_CLASSES       = 8;
    localparam int CLASS_SLOTS       = 8;
    localparam int COST_SHIFT_UNIT   = 1024;
    localparam int DIV_STEPS         = 32;
    localparam int DIVISOR_W         = 27;
    localparam logic [7:0] DEPTH_RESET = 8'd1;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] finish;
        logic [31:0] seq;
        logic [2:0]  cls;
        logic [15:0] tag;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_enq;
        logic class_ok;
        logic free_found;
        logic scan_last;
        logic div_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

@@ rtl/start_time_fair_queue_depth_sched_unit.sv @@
// ----------------------------------------------------------------------------
// start_time_fair_queue_depth_sched_unit: start-time fair queueing scheduler
// Tags, stores and dispatches storage requests with a bounded dispatch depth.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the s_ channel is either an enqueue (s_op low) or a dequeue
// (s_op high), and each produces exactly one result on the m_ channel.
// An enqueue computes the start and finish tags, stores the request in the
// first free queue entry and reports whether a dispatch slot was granted.
// A dequeue removes the stored request with the least start tag, oldest
// arrival first on ties, and returns its tag, class and timestamps.
// One request is handled at a time. Every request sweeps the queue entries
// through the entry RAM read port, one entry per cycle, before its result
// is committed; an enqueue that is stored also runs the cost divider, one
// quotient bit per cycle, between the sweep and the commit. The next request
// can be taken in the cycle after the result is committed; a new request is
// not accepted before the last one is through.
// The result sits in an output register; while the receiver stalls the next
// request is already accepted and worked on, and it waits only to commit.
// The user writes the dispatch_depth register through the cfg_ channel only
// while the block is idle; the block itself does not enforce this. After
// reset the queue is empty, all tags and counters are zero and dispatch_depth
// is one; no clearing pass is needed.
// ----------------------------------------------------------------------------
module start_time_fair_queue_depth_sched_unit #(
    parameter int QUEUE_ENTRIES = sfqd_pkg::QUEUE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [2:0]  s_class_index,
    input  logic [9:0]  s_class_weight,
    input  logic [31:0] s_request_length,
    input  logic [15:0] s_request_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_granted,
    output logic        m_found,
    output logic [15:0] m_out_tag,
    output logic [2:0]  m_out_class,
    output logic [31:0] m_out_start_tag,
    output logic [31:0] m_out_finish_tag,
    output logic        m_queue_full
);
    import sfqd_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // The register is always writable; the user writes it only while idle.
    assign cfg_ready = 1'b1;

    sfqd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sfqd_dp #(
        .QUEUE_ENTRIES (QUEUE_ENTRIES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_op             (s_op),
        .s_class_index    (s_class_index),
        .s_class_weight   (s_class_weight),
        .s_request_length (s_request_length),
        .s_request_tag    (s_request_tag),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_granted        (m_granted),
        .m_found          (m_found),
        .m_out_tag        (m_out_tag),
        .m_out_class      (m_out_class),
        .m_out_start_tag  (m_out_start_tag),
        .m_out_finish_tag (m_out_finish_tag),
        .m_queue_full     (m_queue_full)
    );
endmodule

@@ rtl/sfqd_ram.sv @@
// ----------------------------------------------------------------------------
// sfqd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/sfqd_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfqd_ctrl: scheduler sequencer
// Steps each request through the queue scan, the cost divide of a stored enqueue and the commit.
// ----------------------------------------------------------------------------
module sfqd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sfqd_pkg::ctrl_sts_t sts,
    output sfqd_pkg::ctrl_cmd_t cmd
);
    import sfqd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last entry read is compared at the end of this cycle.
                if (sts.is_enq && sts.class_ok && sts.free_found) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

@@ rtl/sfqd_dp.sv @@
// ----------------------------------------------------------------------------
// sfqd_dp: scheduler datapath
// Scheduler state, entry RAM with scan compare, serial cost divider, result.
// ----------------------------------------------------------------------------
module sfqd_dp #(
    parameter int QUEUE_ENTRIES = sfqd_pkg::QUEUE_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfqd_pkg::ctrl_cmd_t cmd,
    output sfqd_pkg::ctrl_sts_t sts,
    input  logic                s_op,
    input  logic [2:0]          s_class_index,
    input  logic [9:0]          s_class_weight,
    input  logic [31:0]         s_request_length,
    input  logic [15:0]         s_request_tag,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_granted,
    output logic                m_found,
    output logic [15:0]         m_out_tag,
    output logic [2:0]          m_out_class,
    output logic [31:0]         m_out_start_tag,
    output logic [31:0]         m_out_finish_tag,
    output logic                m_queue_full
);
    import sfqd_pkg::*;

    localparam int AW = $clog2(QUEUE_ENTRIES);

    // Scheduler state.
    logic [7:0]              depth_reg;
    logic [31:0]             vtime_reg;
    logic [31:0]             clf_reg [CLASS_SLOTS];
    logic [7:0]              in_flight_reg;
    logic [31:0]             arrival_reg;
    logic [QUEUE_ENTRIES-1:0] valid_reg;

    // Request being worked on.
    logic                    op_reg;
    logic                    class_ok_reg;
    logic [2:0]              cls_reg;
    logic [15:0]             tag_reg;
    logic [31:0]             start_reg;
    logic [DIVISOR_W-1:0]    divisor_reg;

    // Scan.
    logic [AW-1:0]           scan_cnt_reg;
    logic                    pipe_vld_reg;
    logic                    pipe_live_reg;
    logic [AW-1:0]           pipe_idx_reg;
    logic                    free_found_reg;
    logic [AW-1:0]           free_idx_reg;
    logic                    best_found_reg;
    logic [AW-1:0]           best_idx_reg;
    entry_t                  best_reg;
    entry_t                  rd_entry;

    // Divider.
    logic [31:0]             rem_reg;
    logic [31:0]             quo_reg;
    logic [4:0]              div_cnt_reg;

    logic                    m_valid_reg;

    // Combinational helpers.
    logic [9:0]              wt;
    logic [DIVISOR_W-1:0]    divisor_next;
    logic [31:0]             start_next;
    logic [32:0]             rem_sh;
    logic                    ge;
    logic [31:0]             finish;
    logic                    cand_first;
    logic                    enq_ok, enq_full, deq_hit, deq_miss, grant;
    entry_t                  wr_entry;

    assign wt           = (s_class_weight == 10'd0) ? 10'd1 : s_class_weight;
    assign divisor_next = DIVISOR_W'(wt) * DIVISOR_W'(COST_SHIFT_UNIT);
    assign start_next   = (clf_reg[s_class_index] > vtime_reg) ? clf_reg[s_class_index]
                                                              : vtime_reg;

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign ge     = rem_sh >= {{(33 - DIVISOR_W){1'b0}}, divisor_reg};
    // A zero quotient means the weighted unit exceeds the length.
    assign finish = start_reg + ((quo_reg == 32'd0) ? 32'd1 : quo_reg);

    always_comb begin
        if (rd_entry.start != best_reg.start) begin
            cand_first = rd_entry.start < best_reg.start;
        end else begin
            cand_first = (rd_entry.seq - best_reg.seq) >= 32'h8000_0000;
        end
    end

    assign enq_ok   = (op_reg == OP_ENQ) && class_ok_reg && free_found_reg;
    assign enq_full = (op_reg == OP_ENQ) && class_ok_reg && !free_found_reg;
    assign deq_hit  = (op_reg == OP_DEQ) && best_found_reg;
    assign deq_miss = (op_reg == OP_DEQ) && !best_found_reg;
    assign grant    = enq_ok && (in_flight_reg < depth_reg);

    assign wr_entry = '{start: start_reg, finish: finish, seq: arrival_reg,
                        cls: cls_reg, tag: tag_reg};

    sfqd_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.commit && enq_ok),
        .waddr (free_idx_reg),
        .wdata (wr_entry),
        .raddr (scan_cnt_reg),
        .rdata (rd_entry)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg      <= DEPTH_RESET;
            vtime_reg      <= '0;
            for (int i = 0; i < CLASS_SLOTS; i++) begin
                clf_reg[i] <= '0;
            end
            in_flight_reg  <= '0;
            arrival_reg    <= '0;
            valid_reg      <= '0;
            scan_cnt_reg   <= '0;
            pipe_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            div_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                depth_reg <= cfg_data;
            end
            pipe_vld_reg <= cmd.scan_step;
            if (cmd.load) begin
                scan_cnt_reg   <= '0;
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
                div_cnt_reg    <= '0;
            end
            if (cmd.scan_step) begin
                scan_cnt_reg <= scan_cnt_reg + AW'(1);
                if (!valid_reg[scan_cnt_reg] && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (pipe_vld_reg && pipe_live_reg && (!best_found_reg || cand_first)) begin
                best_found_reg <= 1'b1;
            end
            if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
                if (enq_ok) begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    clf_reg[cls_reg]        <= finish;
                    arrival_reg             <= arrival_reg + 32'd1;
                    if (grant) begin
                        in_flight_reg <= in_flight_reg + 8'd1;
                    end
                end
                if (deq_hit) begin
                    valid_reg[best_idx_reg] <= 1'b0;
                    vtime_reg               <= best_reg.start;
                end
                if (deq_miss && in_flight_reg != 8'd0) begin
                    in_flight_reg <= in_flight_reg - 8'd1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= s_op;
            cls_reg      <= s_class_index;
            tag_reg      <= s_request_tag;
            class_ok_reg <= int'(s_class_index) < NUM_CLASSES;
            start_reg    <= start_next;
            divisor_reg  <= divisor_next;
            rem_reg      <= '0;
            quo_reg      <= s_request_length;
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? 32'(rem_sh - {{(33 - DIVISOR_W){1'b0}}, divisor_reg})
                          : rem_sh[31:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
        pipe_idx_reg  <= scan_cnt_reg;
        pipe_live_reg <= valid_reg[scan_cnt_reg];
        if (cmd.scan_step && !valid_reg[scan_cnt_reg] && !free_found_reg) begin
            free_idx_reg <= scan_cnt_reg;
        end
        if (pipe_vld_reg && pipe_live_reg && (!best_found_reg || cand_first)) begin
            best_reg     <= rd_entry;
            best_idx_reg <= pipe_idx_reg;
        end
        if (cmd.commit) begin
            m_granted        <= grant;
            m_found          <= deq_hit;
            m_out_tag        <= deq_hit ? best_reg.tag : 16'd0;
            m_out_class      <= deq_hit ? best_reg.cls : 3'd0;
            m_out_start_tag  <= deq_hit ? best_reg.start : (enq_ok ? start_reg : 32'd0);
            m_out_finish_tag <= deq_hit ? best_reg.finish : (enq_ok ? finish : 32'd0);
            m_queue_full     <= enq_full;
        end
    end

    assign m_valid = m_valid_reg;

    assign sts.is_enq     = (op_reg == OP_ENQ);
    assign sts.class_ok   = class_ok_reg;
    assign sts.free_found = free_found_reg;
    assign sts.scan_last  = (scan_cnt_reg == AW'(QUEUE_ENTRIES - 1));
    assign sts.div_last   = (div_cnt_reg == 5'(DIV_STEPS - 1));
    assign sts.out_free   = !m_valid_reg || m_ready;

    // A stored request always lands in an entry that was free.
    a_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && enq_ok |-> !valid_reg[free_idx_reg])
        else $error("enqueue overwrites an occupied entry");

    // A dispatched request comes from an occupied entry, which is then freed.
    a_deq_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && deq_hit |-> valid_reg[best_idx_reg])
        else $error("dequeue picked a free entry");

    a_deq_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && deq_hit |=> !valid_reg[$past(best_idx_reg)])
        else $error("dispatched entry still occupied");

    // A grant raises the in-flight count by exactly one.
    a_grant_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && grant |=> in_flight_reg == $past(in_flight_reg) + 8'd1)
        else $error("in-flight count not raised on grant");
endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fair queueing request scheduler
// Drives enqueue and dequeue requests and depth settings, predicts every
// result in a behavioral copy of the scheduler and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import sfqd_pkg::*;

    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 2000000;

    // Clock and reset.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // Configuration channel.
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    // Request channel.
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = OP_ENQ;
    logic [2:0]  s_class_index = '0;
    logic [9:0]  s_class_weight = '0;
    logic [31:0] s_request_length = '0;
    logic [15:0] s_request_tag = '0;

    // Result channel.
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_granted;
    logic        m_found;
    logic [15:0] m_out_tag;
    logic [2:0]  m_out_class;
    logic [31:0] m_out_start_tag;
    logic [31:0] m_out_finish_tag;
    logic        m_queue_full;

    // One result of the scheduler, in the order of the output ports.
    typedef struct packed {
        logic        granted;
        logic        found;
        logic [15:0] tag;
        logic [2:0]  cls;
        logic [31:0] start;
        logic [31:0] finish;
        logic        full;
    } verdict_t;

    // One request on the s_ channel.
    typedef struct packed {
        logic        op;
        logic [2:0]  cls;
        logic [9:0]  weight;
        logic [31:0] len;
        logic [15:0] tag;
    } request_t;

    start_time_fair_queue_depth_sched_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_class_index    (s_class_index),
        .s_class_weight   (s_class_weight),
        .s_request_length (s_request_length),
        .s_request_tag    (s_request_tag),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_granted        (m_granted),
        .m_found          (m_found),
        .m_out_tag        (m_out_tag),
        .m_out_class      (m_out_class),
        .m_out_start_tag  (m_out_start_tag),
        .m_out_finish_tag (m_out_finish_tag),
        .m_queue_full     (m_queue_full)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Scheduler shadow state. It is updated at the moment a request is
    // accepted, so that the expected result is known before the block
    // produces it.
    // ------------------------------------------------------------------------
    logic [7:0]  sh_depth;
    logic [31:0] sh_vtime;
    logic [31:0] sh_last_finish [NUM_CLASSES];
    logic [7:0]  sh_in_flight;
    logic [31:0] sh_arrivals;
    logic        sh_used   [SLOTS];
    logic [31:0] sh_start  [SLOTS];
    logic [31:0] sh_finish [SLOTS];
    logic [31:0] sh_seq    [SLOTS];
    logic [2:0]  sh_cls    [SLOTS];
    logic [15:0] sh_tag    [SLOTS];

    verdict_t pending_results[$];
    int       occupancy;
    bit       failed = 1'b0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    task automatic shadow_reset();
        sh_depth = DEPTH_RESET;
        sh_vtime = '0;
        sh_in_flight = '0;
        sh_arrivals = '0;
        occupancy = 0;
        for (int c = 0; c < NUM_CLASSES; c++) sh_last_finish[c] = '0;
        for (int i = 0; i < SLOTS; i++) sh_used[i] = 1'b0;
    endtask

    // Finish tag: one tick for a request cheaper than one weighted unit,
    // otherwise the scaled cost. A weight of zero counts as one.
    function automatic logic [31:0] weighted_finish(logic [31:0] start, logic [31:0] len,
                                                    logic [9:0] weight);
        logic [41:0] w;
        logic [41:0] scaled;
        w = (weight == 0) ? 42'd1 : {32'd0, weight};
        scaled = w * COST_SHIFT_UNIT;
        if (scaled > {10'd0, len}) return start + 32'd1;
        return start + 32'(({10'd0, len} / w) / COST_SHIFT_UNIT);
    endfunction

    // Applies one request to the shadow state and returns its result.
    function automatic verdict_t schedule(request_t r);
        verdict_t v;
        int slot;
        logic [31:0] st;
        v = '0;
        slot = -1;
        if (r.op == OP_ENQ) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!sh_used[i] && slot < 0) slot = i;
            end
            if (slot < 0) begin
                v.full = 1'b1;
                return v;
            end
            st = (sh_last_finish[r.cls] > sh_vtime) ? sh_last_finish[r.cls] : sh_vtime;
            v.start = st;
            v.finish = weighted_finish(st, r.len, r.weight);
            sh_last_finish[r.cls] = v.finish;
            sh_used[slot] = 1'b1;
            sh_start[slot] = st;
            sh_finish[slot] = v.finish;
            sh_seq[slot] = sh_arrivals;
            sh_cls[slot] = r.cls;
            sh_tag[slot] = r.tag;
            sh_arrivals++;
            occupancy++;
            if (sh_in_flight < sh_depth) begin
                sh_in_flight++;
                v.granted = 1'b1;
            end
            return v;
        end
        // Dequeue: least start tag, oldest arrival on a tie.
        for (int i = 0; i < SLOTS; i++) begin
            if (sh_used[i]) begin
                if (slot < 0) slot = i;
                else if (sh_start[i] != sh_start[slot]) begin
                    if (sh_start[i] < sh_start[slot]) slot = i;
                end else if (((sh_seq[i] - sh_seq[slot]) >> 31) != 0) slot = i;
            end
        end
        if (slot < 0) begin
            if (sh_in_flight > 0) sh_in_flight--;
            return v;
        end
        sh_used[slot] = 1'b0;
        occupancy--;
        sh_vtime = sh_start[slot];
        v.found = 1'b1;
        v.tag = sh_tag[slot];
        v.cls = sh_cls[slot];
        v.start = sh_start[slot];
        v.finish = sh_finish[slot];
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every accepted result is compared with the oldest
    // pending expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_granted, m_found, m_out_tag, m_out_class, m_out_start_tag,
                    m_out_finish_tag, m_queue_full};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (got.granted !== want.granted) begin
                    $display("%0t: granted expected %h actual %h", $realtime,
                             want.granted, got.granted);
                    failed = 1'b1;
                end
                if (got.found !== want.found) begin
                    $display("%0t: found expected %h actual %h", $realtime,
                             want.found, got.found);
                    failed = 1'b1;
                end
                if (got.tag !== want.tag) begin
                    $display("%0t: out_tag expected %h actual %h", $realtime,
                             want.tag, got.tag);
                    failed = 1'b1;
                end
                if (got.cls !== want.cls) begin
                    $display("%0t: out_class expected %h actual %h", $realtime,
                             want.cls, got.cls);
                    failed = 1'b1;
                end
                if (got.start !== want.start) begin
                    $display("%0t: out_start_tag expected %h actual %h", $realtime,
                             want.start, got.start);
                    failed = 1'b1;
                end
                if (got.finish !== want.finish) begin
                    $display("%0t: out_finish_tag expected %h actual %h", $realtime,
                             want.finish, got.finish);
                    failed = 1'b1;
                end
                if (got.full !== want.full) begin
                    $display("%0t: queue_full expected %h actual %h", $realtime,
                             want.full, got.full);
                    failed = 1'b1;
                end
            end
        end
    end

    // The receiver stalls at random; ready changes on the falling edge only.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // The run ends at a fixed cycle budget if the block hangs.
    int cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Sends one request and records its expected result when accepted. A
    // typed-in expectation is checked against the predictor as well, so a
    // wrong table row shows up as a mismatch too.
    task automatic send_request(request_t r, bit has_fixed, verdict_t fixed);
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid <= 1'b1;
        s_op <= r.op;
        s_class_index <= r.cls;
        s_class_weight <= r.weight;
        s_request_length <= r.len;
        s_request_tag <= r.tag;
        do @(posedge aclk); while (!s_ready);
        v = schedule(r);
        if (has_fixed && v !== fixed) begin
            $display("%0t: table row expected %h actual %h", $realtime, fixed, v);
            failed = 1'b1;
        end
        pending_results.push_back(v);
        @(negedge aclk);
        s_valid <= 1'b0;
        // The block does not take a new request until this one is through,
        // so the extra wait before the next request loses no rate.
        @(negedge aclk);
    endtask

    // Waits until the block is drained, then writes dispatch_depth.
    task automatic set_depth(logic [7:0] depth);
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= depth;
        do @(posedge aclk); while (!cfg_ready);
        sh_depth = depth;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random request: enqueues at the given percentage, small or full-range
    // weights, lengths spread over small, unit-sized and huge costs.
    function automatic request_t random_request(int enq_pct);
        request_t r;
        r.op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        r.cls = 3'($urandom_range(7));
        case ($urandom_range(3))
            0: r.weight = 10'($urandom_range(1, 4));
            1: r.weight = 10'($urandom);
            default: r.weight = 10'($urandom_range(1, 1023));
        endcase
        case ($urandom_range(3))
            0: r.len = $urandom_range(0, 4096);
            1: r.len = $urandom;
            2: r.len = $urandom_range(1 << 20, 1 << 24);
            default: r.len = {r.weight, 10'd0} + $urandom_range(0, 2) - 1;
        endcase
        r.tag = 16'($urandom);
        return r;
    endfunction

    // Directed table: reset values, field extremes, ties, zero weight, an
    // empty dequeue, and class 3 requests chained on its last finish tag.
    typedef struct {
        request_t req;
        bit       has_fixed;
        verdict_t fixed;
    } row_t;

    row_t plan[] = '{
        // Empty dequeue right after reset: everything zero.
        '{'{OP_DEQ, 3'd0, 10'd1, 32'd0, 16'd0}, 1, '0},
        // Cheap request: finish is start plus one, granted at depth one.
        '{'{OP_ENQ, 3'd0, 10'd1, 32'd0, 16'h0000}, 1,
          '{1'b1, 1'b0, 16'd0, 3'd0, 32'd0, 32'd1, 1'b0}},
        // Depth one already used: stored but not granted.
        '{'{OP_ENQ, 3'd7, 10'd1023, 32'hFFFF_FFFF, 16'hFFFF}, 1,
          '{1'b0, 1'b0, 16'd0, 3'd0, 32'd0, 32'd4100, 1'b0}},
        // Zero weight counts as one.
        '{'{OP_ENQ, 3'd3, 10'd0, 32'hFFFF_FFFF, 16'h1234}, 1,
          '{1'b0, 1'b0, 16'd0, 3'd0, 32'd0, 32'h003F_FFFF, 1'b0}},
        // Length exactly one weighted unit.
        '{'{OP_ENQ, 3'd5, 10'd2, 32'd2048, 16'hA5A5}, 0, '0},
        '{'{OP_ENQ, 3'd5, 10'd2, 32'd2047, 16'h5A5A}, 0, '0},
        // Dequeues: tie at start zero goes to the oldest arrival.
        '{'{OP_DEQ, 3'd0, 10'd1, 32'd0, 16'd0}, 1,
          '{1'b0, 1'b1, 16'h0000, 3'd0, 32'd0, 32'd1, 1'b0}},
        '{'{OP_DEQ, 3'd0, 10'd1, 32'd0, 16'd0}, 1,
          '{1'b0, 1'b1, 16'hFFFF, 3'd7, 32'd0, 32'd4100, 1'b0}},
        '{'{OP_DEQ, 3'd0, 10'd1, 32'd0, 16'd0}, 0, '0},
        '{'{OP_DEQ, 3'd0, 10'd1, 32'd0, 16'd0}, 0, '0},
        '{'{OP_DEQ, 3'd0, 10'd1, 32'd0, 16'd0}, 0, '0},
        // Two more class 3 requests start from its last finish tag.
        '{'{OP_ENQ, 3'd3, 10'd0, 32'hFFFF_FFFF, 16'h0F0F}, 0, '0},
        '{'{OP_ENQ, 3'd3, 10'd1, 32'hFFFF_FFFF, 16'hF0F0}, 0, '0},
        '{'{OP_DEQ, 3'd0, 10'd1, 32'd0, 16'd0}, 0, '0},
        '{'{OP_DEQ, 3'd0, 10'd1, 32'd0, 16'd0}, 0, '0},
        '{'{OP_DEQ, 3'd0, 10'd1, 32'd0, 16'd0}, 0, '0},
        '{'{OP_DEQ, 3'd0, 10'd1, 32'd0, 16'd0}, 0, '0}
    };

    initial begin
        shadow_reset();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) send_request(plan[i].req, plan[i].has_fixed, plan[i].fixed);

        // Fill the queue to the brim and one more: the last is refused.
        set_depth(8'd255);
        for (int i = 0; i <= SLOTS; i++) begin
            request_t r;
            r = random_request(100);
            send_request(r, 0, '0);
        end
        for (int i = 0; i <= SLOTS; i++) send_request('{OP_DEQ, 3'd0, 10'd1, 32'd0,
                                                      16'd0}, 0, '0);

        // Random phases across depth settings and idling patterns.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0: begin send_idle_pct = 36; recv_idle_pct = 47; end
                1: begin send_idle_pct = 47; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (phase)
                0: set_depth(8'd1);
                1: set_depth(8'd0);
                2: set_depth(8'd255);
                3: set_depth(8'd4);
                4: set_depth(8'($urandom_range(1, 254)));
                default: set_depth(8'd128);
            endcase
            for (int n = 0; n < 260; n++) begin
                request_t r;
                // Lean towards filling, then towards draining, so the queue
                // reaches both full and empty.
                r = random_request((occupancy >= SLOTS - 2) ? 30 :
                                   (((n / 65) % 2) == 0) ? 75 : 40);
                send_request(r, 0, '0);
            end
        end

        while (pending_results.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
